@@ design/sfla_pkg.sv @@
// package for the segregated free-list allocator: constants, codes, states
package sfla_pkg;
	localparam int ALIGN_BYTES = 8;
	localparam int NUM_CLASSES = 16;
	localparam int REFILL_BLOCKS = 16;
	localparam int HEAP_BYTES = 65536;
	localparam int ALIGN_SH = $clog2(ALIGN_BYTES);
	localparam int GRANULES = HEAP_BYTES / ALIGN_BYTES;
	localparam int GW = $clog2(GRANULES) + 1;
	localparam int GIW = $clog2(GRANULES);
	localparam int CW = $clog2(NUM_CLASSES);
	localparam int AW = 17;
	localparam int NW = $clog2(REFILL_BLOCKS + 1);
	localparam int MAX_SMALL = ALIGN_BYTES * NUM_CLASSES;
	localparam logic [GW-1:0] NULL_MARK = GW'(GRANULES);

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE = 2'd1,
		ACT_REALLOC = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_TOO_LARGE = 2'd1,
		ST_NO_MEM = 2'd2,
		ST_FREED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_FREE, S_ALLOC, S_POPRD, S_POPWAIT, S_CARVE, S_GROW, S_STEAL,
		S_STEALRD, S_STEALWAIT, S_LINK, S_DONE
	} state_t;
endpackage

@@ design/segregated_free_list_allocator_core.sv @@
// segregated free-list allocator core: sequencer, list heads and link memory
//
// One request is handled at a time; tready is low from acceptance until the result
// transaction is taken. A free goes S_FREE, S_DONE; an allocate adds S_ALLOC, then
// S_DONE if too large or S_POPRD, S_POPWAIT on a list hit. A refill runs S_CARVE and
// one S_LINK write per carved block after the first (up to 15). Growing the pool
// adds S_GROW; a steal of a larger block adds S_STEAL once per size class searched
// (up to 16) and S_STEALWAIT. The link memory is a single port array, read or
// written at most once per cycle, and a read is registered into rd_q.
module segregated_free_list_allocator_core import sfla_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata, // size_bytes, old_size_bytes, block_address
	input  logic [1:0]  s_tuser, // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata, // granted_address
	output logic [1:0]  m_tuser  // status
);
	state_t state_q, state_d;
	logic [GW-1:0] heads_q [NUM_CLASSES];
	logic [GW-1:0] link_mem [GRANULES];
	logic [GW-1:0] rd_q;
	logic [AW-1:0] pb_q, pl_q, hu_q;
	logic [1:0] act_q;
	logic [15:0] size_q, osize_q, addr_q;
	logic [AW-1:0] rb_q, res_q, total_q;
	logic [CW-1:0] cls_q, sc_q;
	logic [NW-1:0] n_q, k_q;
	logic [15:0] out_addr_q;
	status_t out_st_q;
	logic mv_q;

	// combinational helpers
	logic [15:0] fsz;
	logic [AW-1:0] left, rnd_left, get, hu_get, ncalc;
	logic [GW-1:0] fg;
	logic [CW:0] fcls, acls;
	logic wr_en, rd_en;
	logic [GIW-1:0] wr_a, rd_a;
	logic [GW-1:0] wr_d;
	logic [AW-1:0] gaddr, gnext;

	function automatic logic [CW:0] size_cls(input logic [15:0] s);
		logic [15:0] t;
		t = (s == 16'd0) ? 16'(ALIGN_BYTES) : s;
		return (CW+1)'(((t + 16'(ALIGN_BYTES - 1)) >> ALIGN_SH) - 16'd1);
	endfunction

	assign s_tready = (state_q == S_IDLE) && !mv_q;
	assign m_tvalid = mv_q;
	assign m_tdata = out_addr_q;
	assign m_tuser = out_st_q;

	assign fsz = (act_q == ACT_FREE) ? size_q : osize_q;
	assign fcls = size_cls(fsz);
	assign acls = size_cls(size_q);
	assign fg = GW'(addr_q >> ALIGN_SH);
	assign left = pl_q - pb_q;
	assign rnd_left = (left + AW'(ALIGN_BYTES - 1)) >> ALIGN_SH;
	assign get = (total_q << 1) + (((hu_q >> 4) + AW'(ALIGN_BYTES - 1)) >> ALIGN_SH << ALIGN_SH);
	assign hu_get = hu_q + get;
	assign gaddr = res_q + AW'(k_q) * rb_q;
	assign gnext = gaddr + rb_q;

	// whole blocks left in the pool, at most REFILL_BLOCKS, one compare per candidate count
	always_comb begin
		ncalc = '0;
		for (int i = 1; i <= REFILL_BLOCKS; i++)
			if (left >= AW'(i) * rb_q) ncalc = AW'(i);
	end

	always_comb begin
		state_d = state_q;
		wr_en = 1'b0; wr_a = '0; wr_d = '0;
		rd_en = 1'b0; rd_a = '0;
		case (state_q)
			S_IDLE: if (s_tvalid && s_tready) begin
				if (s_tuser == ACT_FREE) state_d = S_FREE;
				else if (s_tuser == ACT_ALLOC || s_tuser == ACT_REALLOC) state_d = S_FREE;
			end
			S_FREE: begin
				if (fsz <= 16'(MAX_SMALL) && !fg[GW-1] && act_q != ACT_ALLOC) begin
					wr_en = 1'b1; wr_a = fg[GIW-1:0]; wr_d = heads_q[fcls[CW-1:0]];
				end
				state_d = (act_q == ACT_FREE) ? S_DONE : S_ALLOC;
			end
			S_ALLOC: state_d = (size_q > 16'(MAX_SMALL)) ? S_DONE :
				(heads_q[cls_q][GW-1] ? S_CARVE : S_POPRD);
			S_POPRD: begin rd_en = 1'b1; rd_a = heads_q[cls_q][GIW-1:0]; state_d = S_POPWAIT; end
			S_POPWAIT: state_d = S_DONE;
			S_CARVE: begin
				if (left >= total_q || left >= rb_q) state_d = (n_q > 1 || ncalc > 1) &&
					!(left < total_q && ncalc <= 1) ? S_LINK : S_DONE;
				else begin
					if (left != 0 && !pb_q[AW-1 -: 1] && (pb_q >> ALIGN_SH) < AW'(GRANULES)) begin
						wr_en = 1'b1; wr_a = GIW'(pb_q >> ALIGN_SH);
						wr_d = heads_q[CW'(rnd_left - 1)];
					end
					state_d = S_GROW;
				end
			end
			S_GROW: state_d = (hu_get <= AW'(HEAP_BYTES)) ? S_CARVE : S_STEAL;
			S_STEAL: begin
				if (!heads_q[sc_q][GW-1]) begin
					rd_en = 1'b1; rd_a = heads_q[sc_q][GIW-1:0]; state_d = S_STEALWAIT;
				end else if (sc_q == CW'(NUM_CLASSES - 1)) state_d = S_DONE;
			end
			S_STEALWAIT: state_d = S_CARVE;
			S_LINK: begin
				if ((gaddr >> ALIGN_SH) < AW'(GRANULES)) begin
					wr_en = 1'b1; wr_a = GIW'(gaddr >> ALIGN_SH);
					wr_d = (k_q == n_q - 1) ? NULL_MARK : GW'(gnext >> ALIGN_SH);
				end
				if (k_q == n_q - 1) state_d = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) link_mem[wr_a] <= wr_d;
		if (rd_en) rd_q <= link_mem[rd_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int c = 0; c < NUM_CLASSES; c++) heads_q[c] <= NULL_MARK;
			pb_q <= '0; pl_q <= '0; hu_q <= '0;
			mv_q <= 1'b0;
			out_st_q <= ST_OK;
		end else begin
			state_q <= state_d;
			if (mv_q && m_tready) mv_q <= 1'b0;
			case (state_q)
				S_IDLE: if (s_tvalid && s_tready) begin
					act_q <= s_tuser;
					size_q <= s_tdata[15:0]; osize_q <= s_tdata[31:16];
					addr_q <= s_tdata[47:32];
					out_addr_q <= '0;
				end
				S_FREE: begin
					if (fsz <= 16'(MAX_SMALL) && !fg[GW-1] && act_q != ACT_ALLOC)
						heads_q[fcls[CW-1:0]] <= fg;
					out_st_q <= (fsz <= 16'(MAX_SMALL)) ? ST_FREED : ST_TOO_LARGE;
					cls_q <= acls[CW-1:0];
					sc_q <= acls[CW-1:0];
					rb_q <= AW'({acls + 1'b1, ALIGN_SH'(0)});
					total_q <= AW'({acls + 1'b1, ALIGN_SH'(0)}) * AW'(REFILL_BLOCKS);
					n_q <= NW'(REFILL_BLOCKS);
					k_q <= NW'(1);
				end
				S_ALLOC: out_st_q <= (size_q > 16'(MAX_SMALL)) ? ST_TOO_LARGE : ST_OK;
				S_POPWAIT: begin
					heads_q[cls_q] <= rd_q;
					out_addr_q <= {heads_q[cls_q][GIW-1:0], ALIGN_SH'(0)};
				end
				S_CARVE: begin
					if (left >= total_q) begin
						res_q <= pb_q; pb_q <= pb_q + total_q;
						out_addr_q <= pb_q[15:0];
						if (n_q > 1) heads_q[cls_q] <= GW'((pb_q + rb_q) >> ALIGN_SH);
					end else if (left >= rb_q) begin
						n_q <= NW'(ncalc);
						res_q <= pb_q; pb_q <= pb_q + ncalc * rb_q;
						out_addr_q <= pb_q[15:0];
						if (ncalc > 1) heads_q[cls_q] <= GW'((pb_q + rb_q) >> ALIGN_SH);
					end else if (left != 0 && (pb_q >> ALIGN_SH) < AW'(GRANULES))
						heads_q[CW'(rnd_left - 1)] <= GW'(pb_q >> ALIGN_SH);
				end
				S_GROW: if (hu_get <= AW'(HEAP_BYTES)) begin
					pb_q <= hu_q; pl_q <= hu_get; hu_q <= hu_get;
				end
				S_STEAL: if (heads_q[sc_q][GW-1]) begin
					if (sc_q == CW'(NUM_CLASSES - 1)) begin
						pb_q <= '0; pl_q <= '0; out_st_q <= ST_NO_MEM;
					end else sc_q <= sc_q + 1'b1;
				end
				S_STEALWAIT: begin
					heads_q[sc_q] <= rd_q;
					pb_q <= AW'(heads_q[sc_q]) << ALIGN_SH;
					pl_q <= (AW'(heads_q[sc_q]) << ALIGN_SH) +
						AW'({{1'b0, sc_q} + 1'b1, ALIGN_SH'(0)});
					sc_q <= cls_q;
				end
				S_LINK: k_q <= k_q + 1'b1;
				S_DONE: mv_q <= 1'b1;
				default: ;
			endcase
		end
	end

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready) else $error("ready while busy");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> m_tvalid) else $error("result lost");
	a_nomem: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_NO_MEM) |-> (pb_q == pl_q)) else $error("pool not empty");
	a_heap: assert property (@(posedge clk) disable iff (!arst_n)
		hu_q <= AW'(HEAP_BYTES)) else $error("heap overrun");
endmodule

@@ sim/segregated_free_list_allocator_core_test.sv @@
// testbench for the segregated free-list allocator core: directed table, random traffic, scoreboard
module segregated_free_list_allocator_core_test;
	import sfla_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata; // size_bytes, old_size_bytes, block_address
	logic [1:0]  s_tuser; // action
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata; // granted_address
	logic [1:0]  m_tuser; // status

	segregated_free_list_allocator_core dut (.*);

	typedef struct {
		logic [1:0]  act;
		logic [15:0] size;
		logic [15:0] old_size;
		logic [15:0] addr;
		bit          typed;
		logic [15:0] g_addr;
		status_t     g_st;
	} req_t;

	typedef struct {
		logic [15:0] g_addr;
		status_t     g_st;
	} grant_t;

	typedef struct {
		logic [15:0] addr;
		logic [15:0] size;
	} block_t;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// allocator shadow state
	int unsigned heads [NUM_CLASSES];
	int unsigned links [GRANULES];
	int unsigned pool_beg, pool_lim, heap_top;

	grant_t grant_q[$];
	block_t held_q[$];
	int errors, n_items, n_ok, n_nomem, n_big, n_freed;
	int snd_idle, rcv_idle;
	bit hold_req;

	req_t dir_tab[] = '{
		'{ACT_ALLOC,   16'd0,      16'd0,      16'h0000, 1, 16'h0000, ST_OK},
		'{ACT_ALLOC,   16'd128,    16'd0,      16'h0000, 0, 16'h0000, ST_OK},
		'{ACT_ALLOC,   16'd129,    16'd0,      16'h0000, 1, 16'h0000, ST_TOO_LARGE},
		'{ACT_ALLOC,   16'hFFFF,   16'hFFFF,   16'hFFFF, 1, 16'h0000, ST_TOO_LARGE},
		'{ACT_FREE,    16'd200,    16'd0,      16'h0000, 1, 16'h0000, ST_TOO_LARGE},
		'{ACT_FREE,    16'd0,      16'd0,      16'h0007, 1, 16'h0000, ST_FREED},
		'{ACT_FREE,    16'd128,    16'd0,      16'hFFF8, 1, 16'h0000, ST_FREED},
		'{ACT_REALLOC, 16'd64,     16'hFFFF,   16'h1234, 0, 16'h0000, ST_OK},
		'{ACT_REALLOC, 16'd0,      16'd8,      16'h0010, 0, 16'h0000, ST_OK},
		'{ACT_UNUSED,  16'hFFFF,   16'hFFFF,   16'hFFFF, 0, 16'h0000, ST_OK},
		'{ACT_REALLOC, 16'd300,    16'd16,     16'h0080, 1, 16'h0000, ST_TOO_LARGE},
		'{ACT_ALLOC,   16'd1,      16'd0,      16'h0000, 0, 16'h0000, ST_OK},
		'{ACT_ALLOC,   16'd9,      16'd0,      16'h0000, 0, 16'h0000, ST_OK},
		'{ACT_ALLOC,   16'd24,     16'd0,      16'h0000, 0, 16'h0000, ST_OK},
		'{ACT_ALLOC,   16'd33,     16'd0,      16'h0000, 0, 16'h0000, ST_OK},
		'{ACT_ALLOC,   16'd56,     16'd0,      16'h0000, 0, 16'h0000, ST_OK},
		'{ACT_ALLOC,   16'd73,     16'd0,      16'h0000, 0, 16'h0000, ST_OK},
		'{ACT_ALLOC,   16'd100,    16'd0,      16'h0000, 0, 16'h0000, ST_OK},
		'{ACT_ALLOC,   16'd127,    16'd0,      16'h0000, 0, 16'h0000, ST_OK},
		'{ACT_FREE,    16'd128,    16'd0,      16'h0080, 0, 16'h0000, ST_FREED},
		'{ACT_ALLOC,   16'd128,    16'd0,      16'h0000, 0, 16'h0000, ST_OK}
	};

	function automatic int unsigned align_up(int unsigned n);
		return ((n + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
	endfunction

	function automatic void list_push(int unsigned cls, int unsigned a);
		int unsigned g;
		g = a / ALIGN_BYTES;
		if (cls >= NUM_CLASSES || g >= GRANULES)
			return;
		links[g] = heads[cls];
		heads[cls] = g;
	endfunction

	function automatic bit list_pop(int unsigned cls, output int unsigned a);
		int unsigned g;
		g = heads[cls];
		a = 0;
		if (g >= GRANULES)
			return 0;
		heads[cls] = links[g];
		a = g * ALIGN_BYTES;
		return 1;
	endfunction

	function automatic bit carve_pool(int unsigned rb, inout int unsigned n,
			output int unsigned res);
		int unsigned total, left, want, a;
		bit found;
		res = 0;
		forever begin
			total = rb * n;
			left = pool_lim - pool_beg;
			if (left >= total) begin
				res = pool_beg;
				pool_beg += total;
				return 1;
			end
			if (left >= rb) begin
				n = left / rb;
				res = pool_beg;
				pool_beg += rb * n;
				return 1;
			end
			want = 2 * total + align_up(heap_top >> 4);
			if (left > 0)
				list_push(align_up(left) / ALIGN_BYTES - 1, pool_beg);
			if (heap_top + want <= HEAP_BYTES) begin
				pool_beg = heap_top;
				pool_lim = pool_beg + want;
				heap_top += want;
			end else begin
				found = 0;
				for (int unsigned c = rb / ALIGN_BYTES - 1; c < NUM_CLASSES; c++) begin
					if (!found && list_pop(c, a)) begin
						pool_beg = a;
						pool_lim = a + (c + 1) * ALIGN_BYTES;
						found = 1;
					end
				end
				if (!found) begin
					pool_beg = 0;
					pool_lim = 0;
					return 0;
				end
			end
		end
	endfunction

	function automatic status_t grant_block(int unsigned size, output int unsigned a);
		int unsigned rb, cls, n, res, g, nx;
		a = 0;
		if (size > MAX_SMALL)
			return ST_TOO_LARGE;
		if (size == 0)
			size = ALIGN_BYTES;
		rb = align_up(size);
		cls = rb / ALIGN_BYTES - 1;
		if (list_pop(cls, a))
			return ST_OK;
		n = REFILL_BLOCKS;
		if (!carve_pool(rb, n, res))
			return ST_NO_MEM;
		if (n > 1) begin
			heads[cls] = (res + rb) / ALIGN_BYTES;
			for (int unsigned k = 1; k < n; k++) begin
				g = (res + k * rb) / ALIGN_BYTES;
				nx = (k == n - 1) ? GRANULES : (res + (k + 1) * rb) / ALIGN_BYTES;
				if (g < GRANULES)
					links[g] = nx;
			end
		end
		a = res;
		return ST_OK;
	endfunction

	function automatic bit release_block(int unsigned size, int unsigned a);
		if (size > MAX_SMALL)
			return 0;
		if (size == 0)
			size = ALIGN_BYTES;
		list_push(align_up(size) / ALIGN_BYTES - 1, a);
		return 1;
	endfunction

	// advance the shadow allocator by one accepted request and queue its grant (none for the unused action code)
	function automatic void predict_grant(req_t r);
		grant_t gr;
		int unsigned a;
		a = 0;
		case (r.act)
			ACT_ALLOC: gr.g_st = grant_block(r.size, a);
			ACT_FREE: gr.g_st = release_block(r.size, r.addr) ? ST_FREED : ST_TOO_LARGE;
			ACT_REALLOC: begin
				void'(release_block(r.old_size, r.addr));
				gr.g_st = grant_block(r.size, a);
			end
			default: return;
		endcase
		gr.g_addr = a[15:0];
		if (r.typed) begin
			if (r.g_addr !== gr.g_addr || r.g_st !== gr.g_st) begin
				$display("%t table row mismatch: typed addr %h st %0d, predicted addr %h st %0d",
					$time, r.g_addr, r.g_st, gr.g_addr, gr.g_st);
				errors++;
			end
			gr.g_addr = r.g_addr;
			gr.g_st = r.g_st;
		end
		if (gr.g_st == ST_OK && r.act != ACT_FREE)
			held_q.push_back('{gr.g_addr, r.size});
		grant_q.push_back(gr);
	endfunction

	task automatic send_req(req_t r);
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.act;
		s_tdata <= {r.addr, r.old_size, r.size};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_items++;
		predict_grant(r);
	endtask

	function automatic logic [15:0] any_size();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 90)
			return 16'($urandom_range(MAX_SMALL));
		return 16'($urandom);
	endfunction

	function automatic req_t random_req();
		req_t r;
		int unsigned p, i;
		block_t b;
		r = '{ACT_ALLOC, 16'd0, 16'd0, 16'd0, 0, 16'd0, ST_OK};
		p = $urandom_range(99);
		if (p < 55 || (p < 90 && held_q.size() == 0)) begin
			r.size = any_size();
		end else if (p < 80) begin
			i = $urandom_range(held_q.size() - 1);
			b = held_q[i];
			held_q.delete(i);
			r.act = ACT_FREE;
			r.size = b.size;
			r.addr = b.addr;
		end else if (p < 90) begin
			i = $urandom_range(held_q.size() - 1);
			b = held_q[i];
			held_q.delete(i);
			r.act = ACT_REALLOC;
			r.size = any_size();
			r.old_size = b.size;
			r.addr = b.addr;
		end else begin
			// noise: raw fields, bogus frees, unused action code
			r.act = 2'($urandom);
			r.size = 16'($urandom);
			r.old_size = 16'($urandom);
			r.addr = 16'($urandom);
			if (p < 95)
				r.size = 16'(r.size % (MAX_SMALL + 1));
		end
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	// result side: scoreboard and ready pattern
	initial begin
		int hold_cnt;
		grant_t gr;
		hold_cnt = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (grant_q.size() == 0) begin
					$display("%t unexpected transaction: addr %h status %0d",
						$time, m_tdata, m_tuser);
					errors++;
				end else begin
					gr = grant_q.pop_front();
					if (m_tdata !== gr.g_addr || m_tuser !== gr.g_st) begin
						$display("%t mismatch: expected addr %h status %0d, got addr %h status %0d",
							$time, gr.g_addr, gr.g_st, m_tdata, m_tuser);
						errors++;
					end
					case (gr.g_st)
						ST_OK: n_ok++;
						ST_NO_MEM: n_nomem++;
						ST_TOO_LARGE: n_big++;
						default: n_freed++;
					endcase
				end
			end
			if (hold_req) begin
				hold_req = 0;
				hold_cnt = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_idle);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		errors = 0;
		hold_req = 0;
		snd_idle = 31;
		rcv_idle = 66;
		foreach (heads[c])
			heads[c] = GRANULES;
		pool_beg = 0;
		pool_lim = 0;
		heap_top = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i])
			send_req(dir_tab[i]);
		hold_req = 1;
		for (int ph = 0; ph < 3; ph++) begin
			snd_idle = (ph == 0) ? 31 : (ph == 1) ? 66 : 0;
			rcv_idle = (ph == 0) ? 66 : (ph == 1) ? 31 : 0;
			repeat (500)
				send_req(random_req());
		end
		s_tvalid <= 1'b0;
		wait (grant_q.size() == 0);
		repeat (60) @(posedge clk);
		$display("%0d requests: %0d granted, %0d out of memory, %0d too large, %0d freed",
			n_items, n_ok, n_nomem, n_big, n_freed);
		$display("covered size extremes, unaligned and oversized frees, refill, grow and steal");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
